FILE: hdl/vdu_pkg.sv
`timescale 1ns / 1ps
package vdu_pkg;

  localparam int ElemBits   = 16;
  localparam int MaxLength  = 4096;
  localparam int LenBits    = 13;
  localparam int CountBits  = 13;
  localparam int DotBits    = 44;
  localparam int NormBits   = 43;
  localparam int DiffBits   = 45;
  localparam int OutBits    = 48;
  localparam int FracOut    = 24;
  localparam int RadBits    = 2 * NormBits;
  localparam int RootBits   = NormBits;
  localparam int RemBits    = RootBits + 3;
  localparam int MulSteps   = NormBits;
  localparam int SqrtSteps  = RootBits;
  localparam int DivSteps   = FracOut;
  localparam int IterBits   = 6;

  localparam logic [1:0] METRIC_L2     = 2'd0;
  localparam logic [1:0] METRIC_COSINE = 2'd1;

  localparam logic CFG_METRIC = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef struct packed {
    logic acc_en;
    logic mul_load;
    logic mul_step;
    logic sqrt_load_diff;
    logic sqrt_load_prod;
    logic sqrt_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } vdu_cmd_t;

  typedef struct packed {
    logic       last;
    logic [1:0] metric;
    logic       root_zero;
    logic       mag_ge_den;
  } vdu_sts_t;

endpackage

FILE: hdl/vdu_ctrl.sv
`timescale 1ns / 1ps
module vdu_ctrl import vdu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  vdu_sts_t sts,
  output vdu_cmd_t cmd
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SLD   = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [IterBits-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  assign in_ready  = (state_r == S_ACC);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_ACC: begin
        cmd.acc_en = accept;
        if (accept && sts.last) state_nxt = S_START;
      end
      S_START: begin
        cnt_nxt = '0;
        if (sts.metric == METRIC_L2) begin
          cmd.sqrt_load_diff = 1'b1;
          state_nxt = S_SQRT;
        end else if (sts.metric == METRIC_COSINE) begin
          cmd.mul_load = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IterBits'(MulSteps - 1)) state_nxt = S_SLD;
      end
      S_SLD: begin
        cmd.sqrt_load_prod = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IterBits'(SqrtSteps - 1))
          state_nxt = (sts.metric == METRIC_COSINE) ? S_CHK : S_DONE;
      end
      S_CHK: begin
        cnt_nxt = '0;
        if (sts.root_zero || sts.mag_ge_den) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_load = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IterBits'(DivSteps - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/vdu_datapath.sv
`timescale 1ns / 1ps
module vdu_datapath import vdu_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [ElemBits-1:0] in_lhs_element,
  input  logic signed [ElemBits-1:0] in_rhs_element,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [LenBits-1:0]         cfg_wdata,
  input  vdu_cmd_t                   cmd,
  output vdu_sts_t                   sts,
  output logic signed [OutBits-1:0]  out_distance,
  output logic                       out_zero_norm
);

  logic [1:0]          metric_r;
  logic [LenBits-1:0]  length_r;
  logic [CountBits-1:0] count_r;
  logic [DotBits-1:0]  dot_r;
  logic [NormBits-1:0] lnorm_r, rnorm_r;
  logic [DiffBits-1:0] diff_r;

  logic [RadBits-1:0]  mcand_r, prod_r;
  logic [NormBits-1:0] mplier_r;
  logic [RadBits-1:0]  rad_r;
  logic [RemBits-1:0]  rem_r;
  logic [RootBits-1:0] root_r;
  logic [DotBits:0]    div_r;
  logic [FracOut-1:0]  quo_r;

  logic signed [OutBits-1:0] dist_r;
  logic                      zn_r;

  logic signed [2*ElemBits-1:0] p_dot, p_l, p_r;
  logic signed [ElemBits:0]      d;
  logic [2*ElemBits+1:0]         p_d;
  logic [CountBits-1:0]          eff_len;
  logic [CountBits:0]            count_inc;
  logic signed [DotBits-1:0]     dot_s;
  logic                          neg;
  logic [DotBits-1:0]            mag;
  logic [RemBits-1:0]            rem_sh, trial;
  logic [DotBits:0]              div_sh;
  logic signed [OutBits-1:0]     sim, dist_nxt;

  assign p_dot = in_lhs_element * in_rhs_element;
  assign p_l   = in_lhs_element * in_lhs_element;
  assign p_r   = in_rhs_element * in_rhs_element;
  assign d     = ElemBits'(0) + (ElemBits+1)'(in_lhs_element) - (ElemBits+1)'(in_rhs_element);
  assign p_d   = (2*ElemBits+2)'(d * d);

  // vector length 0 acts as 1, anything above the max clamps
  always_comb begin
    if (length_r == '0) eff_len = CountBits'(1);
    else if (length_r > LenBits'(MaxLength)) eff_len = CountBits'(MaxLength);
    else eff_len = length_r;
  end
  assign count_inc = {1'b0, count_r} + 1'b1;

  assign dot_s = dot_r;
  assign neg   = dot_s < 0;
  assign mag   = neg ? (~dot_r + 1'b1) : dot_r;

  assign rem_sh = {rem_r[RemBits-3:0], rad_r[RadBits-1 -: 2]};
  assign trial  = RemBits'({root_r, 2'b01});
  assign div_sh = {div_r[DotBits-1:0], 1'b0};

  assign sts.last       = count_inc >= {1'b0, eff_len};
  assign sts.metric     = metric_r;
  assign sts.root_zero  = (root_r == '0);
  assign sts.mag_ge_den = mag >= DotBits'(root_r);

  always_comb begin
    sim = sts.mag_ge_den ? OutBits'(64'd1 << FracOut) : OutBits'(quo_r);
    if (metric_r == METRIC_L2) begin
      dist_nxt = OutBits'(root_r);
    end else if (metric_r == METRIC_COSINE) begin
      if (sts.root_zero) dist_nxt = OutBits'(64'd1 << FracOut);
      else dist_nxt = OutBits'(64'd1 << FracOut) - (neg ? -sim : sim);
    end else begin
      dist_nxt = -OutBits'(dot_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= '0;
      length_r <= LenBits'(128);
    end else if (cfg_we) begin
      if (cfg_index == CFG_METRIC) metric_r <= cfg_wdata[1:0];
      else length_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      count_r <= '0;
      dot_r   <= '0;
      lnorm_r <= '0;
      rnorm_r <= '0;
      diff_r  <= '0;
    end else if (cmd.acc_en) begin
      count_r <= count_inc[CountBits-1:0];
      dot_r   <= dot_r + DotBits'(p_dot);
      lnorm_r <= lnorm_r + NormBits'(p_l);
      rnorm_r <= rnorm_r + NormBits'(p_r);
      diff_r  <= diff_r + DiffBits'(p_d);
    end
  end

  // shift-add multiplier for the norm product, one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mcand_r  <= RadBits'(lnorm_r);
      mplier_r <= rnorm_r;
      prod_r   <= '0;
    end else if (cmd.mul_step) begin
      if (mplier_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r  <= {mcand_r[RadBits-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[NormBits-1:1]};
    end
  end

  // restoring square root, one root bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.sqrt_load_diff || cmd.sqrt_load_prod) begin
      rad_r  <= cmd.sqrt_load_prod ? prod_r : RadBits'({diff_r, {FracOut{1'b0}}});
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r <= {rad_r[RadBits-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[RootBits-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[RootBits-2:0], 1'b0};
      end
    end
  end

  // restoring divide for the fractional similarity
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_r <= {1'b0, mag};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (div_sh >= (DotBits+1)'(root_r)) begin
        div_r <= div_sh - (DotBits+1)'(root_r);
        quo_r <= {quo_r[FracOut-2:0], 1'b1};
      end else begin
        div_r <= div_sh;
        quo_r <= {quo_r[FracOut-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dist_r <= dist_nxt;
      zn_r   <= (metric_r == METRIC_COSINE) && sts.root_zero;
    end
  end

  assign out_distance  = dist_r;
  assign out_zero_norm = zn_r;

endmodule

FILE: hdl/vector_distance_unit.sv
`timescale 1ns / 1ps
// Streams element pairs (signed Q4.12) into dot, norm and difference sums at
// one pair per cycle; after vector_length pairs it computes one Q23.24
// distance and holds input off until the result is in the output register.
// Back-end per vector: negative inner product goes straight to the output,
// euclidean runs a 43-step root, cosine a 43-step shift-add norm product,
// a 43-step root and up to a 24-step divide, on serial units (the root
// serves both), then waits while the output register holds an unread result.
module vector_distance_unit import vdu_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [ElemBits-1:0] in_lhs_element,
  input  logic signed [ElemBits-1:0] in_rhs_element,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OutBits-1:0]  out_distance,
  output logic                       out_zero_norm,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [LenBits-1:0]         cfg_wdata
);

  vdu_cmd_t cmd;
  vdu_sts_t sts;

  vdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  vdu_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_lhs_element (in_lhs_element),
    .in_rhs_element (in_rhs_element),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_distance   (out_distance),
    .out_zero_norm  (out_zero_norm)
  );

endmodule

FILE: bench/vector_distance_unit_tb.sv
`timescale 1ns / 1ps
module vector_distance_unit_tb;
  import vdu_pkg::*;

  localparam logic [1:0] METRIC_INNER  = 2'd2;
  localparam logic [1:0] METRIC_UNUSED = 2'd3;
  localparam int         BackEndWait   = 150;

  typedef struct packed {
    logic [OutBits-1:0] distance;
    logic               zero_norm;
  } distance_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [ElemBits-1:0] in_lhs_element;
  logic signed [ElemBits-1:0] in_rhs_element;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [OutBits-1:0]  out_distance;
  logic                       out_zero_norm;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [LenBits-1:0]         cfg_wdata;

  // predictor copy of the block state
  logic [1:0]          pred_metric;
  logic [LenBits-1:0]  pred_length;
  logic [CountBits-1:0] pred_count;
  logic [DotBits-1:0]  pred_dot;
  logic [NormBits-1:0] pred_left;
  logic [NormBits-1:0] pred_right;
  logic [DiffBits-1:0] pred_diff;

  distance_t pending_distances[$];
  int        mismatch_count;
  int        sent_pairs;
  bit        idle_enable;

  vector_distance_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_lhs_element (in_lhs_element),
    .in_rhs_element (in_rhs_element),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_distance   (out_distance),
    .out_zero_norm  (out_zero_norm),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] floor_sqrt(logic [127:0] rad);
    logic [127:0] rem;
    logic [127:0] trial;
    logic [63:0]  root;
    rem  = '0;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      rem   = (rem << 2) | ((rad >> (2 * k)) & 128'd3);
      trial = {root, 2'b01};
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  function automatic logic [CountBits-1:0] effective_length();
    if (pred_length == 0) return CountBits'(1);
    if (pred_length > MaxLength) return CountBits'(MaxLength);
    return pred_length;
  endfunction

  // folds one pair into the sums; pushes a distance when the vector completes
  task automatic fold_pair(logic signed [ElemBits-1:0] a, logic signed [ElemBits-1:0] b);
    longint       la;
    longint       lb;
    longint       ld;
    longint       predicted;
    longint       dot;
    longint       sim;
    logic [63:0]  den;
    logic [63:0]  mag;
    logic [63:0]  q;
    logic [63:0]  r;
    logic [127:0] rad;
    distance_t    res;
    la = a;
    lb = b;
    ld = la - lb;
    pred_dot   = pred_dot + DotBits'(la * lb);
    pred_left  = pred_left + NormBits'(la * la);
    pred_right = pred_right + NormBits'(lb * lb);
    pred_diff  = pred_diff + DiffBits'(ld * ld);
    pred_count = pred_count + 1'b1;
    if (pred_count < effective_length()) return;
    res.zero_norm = 1'b0;
    dot = longint'(signed'(pred_dot));
    if (pred_metric == METRIC_L2) begin
      rad  = 128'(pred_diff) << FracOut;
      predicted = longint'(floor_sqrt(rad));
    end else if (pred_metric == METRIC_COSINE) begin
      rad = 128'(pred_left) * 128'(pred_right);
      den = floor_sqrt(rad);
      if (den == 0) begin
        predicted = longint'(1) << FracOut;
        res.zero_norm = 1'b1;
      end else begin
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        if (mag >= den) begin
          sim = longint'(1) << FracOut;
        end else begin
          q = '0;
          r = mag;
          for (int i = 0; i < FracOut; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
              r = r - den;
              q = q | 64'd1;
            end
          end
          sim = longint'(q);
        end
        predicted = (longint'(1) << FracOut) - ((dot < 0) ? -sim : sim);
      end
    end else begin
      predicted = -dot;
    end
    if (predicted > (longint'(1) << (OutBits - 1)) - 1)
      predicted = (longint'(1) << (OutBits - 1)) - 1;
    if (predicted < -(longint'(1) << (OutBits - 1)))
      predicted = -(longint'(1) << (OutBits - 1));
    res.distance = OutBits'(predicted);
    pending_distances.push_back(res);
    pred_count = '0;
    pred_dot   = '0;
    pred_left  = '0;
    pred_right = '0;
    pred_diff  = '0;
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // result side: random stalls, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    distance_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_enable || ($urandom_range(99) >= 33);
      if (out_valid && out_ready) begin
        if (pending_distances.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pending_distances.pop_front();
          if (out_distance !== want.distance)
            report_mismatch($sformatf("distance %0d expected %0d",
                                      out_distance, signed'(want.distance)));
          if (out_zero_norm !== want.zero_norm)
            report_mismatch($sformatf("zero_norm %0b expected %0b",
                                      out_zero_norm, want.zero_norm));
        end
      end
    end
  end

  task automatic send_pair(logic signed [ElemBits-1:0] a, logic signed [ElemBits-1:0] b);
    if (idle_enable && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_valid       <= 1'b1;
    in_lhs_element <= a;
    in_rhs_element <= b;
    do @(posedge clk); while (!in_ready);
    fold_pair(a, b);
    sent_pairs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (BackEndWait) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [LenBits-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_METRIC) pred_metric = value[1:0];
    else pred_length = value;
    @(posedge clk);
  endtask

  task automatic setup(logic [1:0] metric, logic [LenBits-1:0] len);
    drain();
    write_reg(CFG_METRIC, LenBits'(metric));
    write_reg(CFG_LENGTH, len);
  endtask

  function automatic logic [ElemBits-1:0] rand_element();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      default: return ElemBits'($urandom);
    endcase
  endfunction

  task automatic test_euclidean_extremes();
    setup(METRIC_L2, LenBits'(1));
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'sh1000, 16'sh1000);
  endtask

  task automatic test_cosine_cases();
    setup(METRIC_COSINE, LenBits'(2));
    send_pair(16'sh0000, 16'sh1234);  // zero left norm
    send_pair(16'sh0000, 16'sh7fff);
    send_pair(16'sh1000, 16'sh1000);  // parallel, similarity clamps to one
    send_pair(16'sh2000, 16'sh2000);
    send_pair(16'sh7fff, 16'sh8000);  // opposite
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh1000, 16'sh0000);  // orthogonal
    send_pair(16'sh0000, 16'sh1000);
    send_pair(16'sh1000, 16'sh0800);
    send_pair(16'sh0400, 16'sh1000);
  endtask

  task automatic test_inner_product();
    setup(METRIC_INNER, LenBits'(1));
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    setup(METRIC_UNUSED, LenBits'(1));  // unused code acts as inner product
    send_pair(16'sh7fff, 16'sh7fff);
    send_pair(16'sh8000, 16'sh7fff);
  endtask

  task automatic test_length_limits();
    setup(METRIC_L2, LenBits'(0));  // zero acts as one
    send_pair(16'sh7fff, 16'sh0000);
    send_pair(16'sh0001, 16'sh8000);
    setup(METRIC_COSINE, LenBits'(256));
    for (int i = 0; i < 256; i++) send_pair(16'sh8000, 16'sh7fff);
    // above the maximum: no result yet, the sums carry into a shorter length
    setup(METRIC_INNER, {LenBits{1'b1}});
    repeat (8) send_pair(16'sh8000, 16'sh8000);
    setup(METRIC_INNER, LenBits'(8));
    send_pair(16'sh8000, 16'sh8000);
  endtask

  task automatic test_partial_vector_reconfig();
    setup(METRIC_L2, LenBits'(5));
    repeat (3) send_pair(rand_element(), rand_element());
    setup(METRIC_COSINE, LenBits'(3));  // count already at the length completes on next pair
    send_pair(rand_element(), rand_element());
  endtask

  task automatic test_random_vectors();
    int len;
    while (sent_pairs < 1600) begin
      idle_enable = ($urandom_range(5) != 0);
      len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(1, 16);
      setup(2'($urandom_range(3)), LenBits'(len));
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(9) == 0) begin
          for (int i = 0; i < (len == 0 ? 1 : len); i++)
            send_pair('0, ElemBits'($urandom));
        end else begin
          for (int i = 0; i < (len == 0 ? 1 : len); i++)
            send_pair(rand_element(), rand_element());
        end
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_lhs_element = '0;
    in_rhs_element = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_METRIC;
    cfg_wdata      = '0;
    mismatch_count = 0;
    sent_pairs     = 0;
    idle_enable    = 1'b1;
    pred_metric    = METRIC_L2;
    pred_length    = 13'd128;
    pred_count     = '0;
    pred_dot       = '0;
    pred_left      = '0;
    pred_right     = '0;
    pred_diff      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_euclidean_extremes();
    test_cosine_cases();
    test_inner_product();
    test_length_limits();
    test_partial_vector_reconfig();
    test_random_vectors();
    drain();
    if (mismatch_count == 0) begin
      $display("PASS vector_distance_unit");
    end else begin
      $display("FAIL vector_distance_unit");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL vector_distance_unit");
    $finish;
  end

endmodule

FILE: sim.f
hdl/vdu_pkg.sv
hdl/vdu_ctrl.sv
hdl/vdu_datapath.sv
hdl/vector_distance_unit.sv
bench/vector_distance_unit_tb.sv
